### rtl/pfv_pkg.sv
package pfv_pkg;

  localparam int POS_W     = 48;
  localparam int ACC_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int Q_PTR_W   = $clog2(QDEPTH);
  localparam int Q_CNT_W   = $clog2(QDEPTH + 1);

  // shared divider is used for k, w1, w and the mass divide
  localparam int N_DIVS    = 4;
  localparam int DIVN_W    = $clog2(N_DIVS);
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SQ_STEPS  = 50;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int ROOT_W    = SQ_STEPS;
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int SQ_REM_W  = ROOT_W + 4;
  localparam int MUL_PH_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA  = 3'd4;

  localparam logic [POS_W-1:0] CUTOFF_RST = 48'd42949673;
  localparam logic [POS_W-1:0] MINR_RST   = 48'd429497;
  localparam logic [POS_W-1:0] MASS_RST   = 48'd42949673;
  localparam logic [POS_W-1:0] STEP_RST   = 48'd2147484;
  localparam logic [POS_W-1:0] ARENA_RST  = 48'd4294967296;

  localparam logic signed [ACC_W-1:0] ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN    = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] V_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] V_MIN      = 64'shFFFF_8000_0000_0000;
  localparam logic signed [ACC_W-1:0] STEP_LIMIT = 64'sh1000_0000_0000_0000;

  typedef struct packed {
    logic        [POS_W-1:0] own_x;
    logic        [POS_W-1:0] own_y;
    logic signed [POS_W-1:0] own_vx;
    logic signed [POS_W-1:0] own_vy;
    logic        [POS_W-1:0] nbr_x;
    logic        [POS_W-1:0] nbr_y;
    logic                    last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic        [POS_W-1:0] new_x;
    logic        [POS_W-1:0] new_y;
    logic signed [POS_W-1:0] new_vx;
    logic signed [POS_W-1:0] new_vy;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    logic        [POS_W-1:0] own_x;
    logic        [POS_W-1:0] own_y;
    logic signed [POS_W-1:0] own_vx;
    logic signed [POS_W-1:0] own_vy;
    logic        [POS_W-1:0] dx_mag;
    logic                    dx_neg;
    logic        [POS_W-1:0] dy_mag;
    logic                    dy_neg;
    logic                    last_neighbor;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_W,
    ST_ROOT,
    ST_ROOT_W,
    ST_DIV,
    ST_DIV_W,
    ST_ACC,
    ST_CHK,
    ST_VADD,
    ST_POS,
    ST_BNC,
    ST_CLP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MOP_DX2,
    MOP_DY2,
    MOP_M2,
    MOP_C2,
    MOP_TERM,
    MOP_VEL,
    MOP_POS
  } mul_op_t;

endpackage

### rtl/particle_force_and_verlet_step.sv
// beyond the cutoff an item needs only four squaring multiplies; inside it, also the root,
//   divides and a multiply per axis; the item closing a run adds integration and output
// a new item is taken only once the last is done; a 64-step shared divider run four times
//   per item inside the cutoff dominates, with a 50-step square root and a 64x64 multiplier
// the two-entry input queue accepts until full while the sequencer or the output is busy
// reset (rst, synchronous): control and accumulators cleared, registers at defaults
module particle_force_and_verlet_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pfv_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pfv_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfv_pkg::POS_W-1:0]           cfg_data
);
  import pfv_pkg::*;

  function automatic logic signed [ACC_W-1:0] ssat(input logic ng, input logic [63:0] mag);
    if (ng) begin
      return mag[63] ? ACC_MIN : $signed(64'd0 - mag);
    end
    return mag[63] ? ACC_MAX : $signed(mag);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return $signed(s[ACC_W-1:0]);
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_v(input logic signed [ACC_W-1:0] v);
    if (v > V_MAX) begin
      return V_MAX;
    end
    if (v < V_MIN) begin
      return V_MIN;
    end
    return v;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_step(input logic signed [ACC_W-1:0] v);
    if (v > STEP_LIMIT) begin
      return STEP_LIMIT;
    end
    if (v < -STEP_LIMIT) begin
      return -STEP_LIMIT;
    end
    return v;
  endfunction

  logic [POS_W-1:0] cutoff;
  logic [POS_W-1:0] minr;
  logic [POS_W-1:0] mass;
  logic [POS_W-1:0] tstep;
  logic [POS_W-1:0] arena;

  state_t  state;
  state_t  state_next;
  mul_op_t mop;
  work_t   wk;
  work_t   q_head;
  logic    q_avail;
  logic    q_pop;
  logic    axis;

  logic [96:0]              d2;
  logic [95:0]              m2;
  logic [ROOT_W-1:0]        rr;
  logic                     neg;
  logic [ROOT_W-1:0]        amag;
  logic [63:0]              qv;
  logic [DIVN_W-1:0]        divn;
  logic signed [ACC_W-1:0]  accx;
  logic signed [ACC_W-1:0]  accy;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  tmp;
  logic signed [ACC_W-1:0]  vtmp;
  logic signed [ACC_W-1:0]  dp;
  logic signed [ACC_W-1:0]  pw;
  logic signed [ACC_W-1:0]  pf;
  logic [POS_W-1:0]         rx;
  logic [POS_W-1:0]         ry;
  logic signed [POS_W-1:0]  rvx;
  logic signed [POS_W-1:0]  rvy;

  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [ACC_W-1:0]  vel_sel;
  logic signed [ACC_W-1:0]  pos_sel;
  logic signed [ACC_W-1:0]  s64;
  logic [POS_W-1:0]         dmag_sel;
  logic                     dneg_sel;
  logic [63:0]              acc_mag;
  logic [63:0]              v_mag;
  logic [POS_W-1:0]         mass_eff;

  logic         mul_start;
  logic         mul_done;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [127:0] prod;
  logic         sq_start;
  logic         sq_done;
  logic [ROOT_W-1:0] root;
  logic         dv_start;
  logic         dv_done;
  logic [127:0] dv_num;
  logic [63:0]  dv_den;
  logic [63:0]  quo;
  logic         emit_go;

  pfv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  pfv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pfv_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   ({3'd0, d2}),
    .done  (sq_done),
    .root  (root)
  );

  pfv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (quo)
  );

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RST;
      minr   <= MINR_RST;
      mass   <= MASS_RST;
      tstep  <= STEP_RST;
      arena  <= ARENA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CUTOFF: cutoff <= cfg_data;
        REG_MINR:   minr   <= cfg_data;
        REG_MASS:   mass   <= cfg_data;
        REG_STEP:   tstep  <= cfg_data;
        REG_ARENA:  arena  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // per-axis operand selection
  always_comb begin
    acc_sel  = axis ? accy : accx;
    dmag_sel = axis ? wk.dy_mag : wk.dx_mag;
    dneg_sel = axis ? wk.dy_neg : wk.dx_neg;
    vel_sel  = axis ? {{16{wk.own_vy[POS_W-1]}}, wk.own_vy}
                    : {{16{wk.own_vx[POS_W-1]}}, wk.own_vx};
    pos_sel  = axis ? {16'd0, wk.own_y} : {16'd0, wk.own_x};
    s64      = {16'd0, arena};
    acc_mag  = acc_sel[ACC_W-1] ? 64'd0 - acc_sel : acc_sel;
    v_mag    = vtmp[ACC_W-1] ? 64'd0 - vtmp : vtmp;
    mass_eff = (mass == '0) ? POS_W'(1) : mass;
    emit_go  = (state == ST_EMIT) && (!out_valid || !out_stall);
    if (pw < 0) begin
      pf = '0;
    end else if (pw > s64) begin
      pf = s64;
    end else begin
      pf = pw;
    end
  end

  always_comb begin
    case (mop)
      MOP_DX2:  begin mul_a = 64'(wk.dx_mag); mul_b = 64'(wk.dx_mag); end
      MOP_DY2:  begin mul_a = 64'(wk.dy_mag); mul_b = 64'(wk.dy_mag); end
      MOP_M2:   begin mul_a = 64'(minr);      mul_b = 64'(minr);      end
      MOP_C2:   begin mul_a = 64'(cutoff);    mul_b = 64'(cutoff);    end
      MOP_TERM: begin mul_a = qv;             mul_b = 64'(dmag_sel);  end
      MOP_VEL:  begin mul_a = acc_mag;        mul_b = 64'(tstep);     end
      MOP_POS:  begin mul_a = v_mag;          mul_b = 64'(tstep);     end
      default:  begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  // k, w1, w divide by the radius; the last pass divides by the mass
  always_comb begin
    dv_num = {32'd0, (divn == '0) ? 64'(amag) : qv, 32'd0};
    dv_den = (divn == DIVN_W'(N_DIVS - 1)) ? 64'(mass_eff) : 64'(rr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_avail) begin
          q_pop      = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_W;
      end
      ST_MUL_W: begin
        if (mul_done) begin
          case (mop)
            MOP_DX2, MOP_DY2, MOP_M2: state_next = ST_MUL;
            MOP_C2:   state_next = (d2 > prod[96:0]) ? ST_CHK : ST_ROOT;
            MOP_TERM: state_next = ST_ACC;
            MOP_VEL:  state_next = ST_VADD;
            MOP_POS:  state_next = ST_POS;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ROOT: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT_W;
      end
      ST_ROOT_W: begin
        if (sq_done) begin
          state_next = (root == '0) ? ST_CHK : ST_DIV;
        end
      end
      ST_DIV: begin
        dv_start   = 1'b1;
        state_next = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (dv_done) begin
          state_next = (divn == DIVN_W'(N_DIVS - 1)) ? ST_MUL : ST_DIV;
        end
      end
      ST_ACC:  state_next = axis ? ST_CHK : ST_MUL;
      ST_CHK:  state_next = wk.last_neighbor ? ST_MUL : ST_IDLE;
      ST_VADD: state_next = ST_MUL;
      ST_POS:  state_next = ST_BNC;
      ST_BNC:  state_next = ST_CLP;
      ST_CLP:  state_next = axis ? ST_EMIT : ST_MUL;
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accx      <= '0;
      accy      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_avail) begin
            wk   <= q_head;
            mop  <= MOP_DX2;
            axis <= 1'b0;
          end
        end
        ST_MUL_W: begin
          if (mul_done) begin
            case (mop)
              MOP_DX2: begin
                d2  <= prod[96:0];
                mop <= MOP_DY2;
              end
              MOP_DY2: begin
                d2  <= d2 + prod[96:0];
                mop <= MOP_M2;
              end
              MOP_M2: begin
                m2  <= prod[95:0];
                mop <= MOP_C2;
              end
              MOP_C2: begin
                if ({1'b0, m2} > d2) begin
                  d2 <= {1'b0, m2};
                end
              end
              MOP_TERM: term <= ssat(neg ^ dneg_sel,
                                     (prod[127:104] != '0) ? '1 : prod[103:40]);
              MOP_VEL:  tmp  <= ssat(acc_sel[ACC_W-1],
                                     (prod[127:88] != '0) ? '1 : prod[87:24]);
              MOP_POS:  dp   <= clamp_step(ssat(vtmp[ACC_W-1],
                                     (prod[127:96] != '0) ? '1 : prod[95:32]));
              default:  ;
            endcase
          end
        end
        ST_ROOT_W: begin
          if (sq_done) begin
            rr   <= root;
            neg  <= root < {2'b00, cutoff};
            amag <= (root < {2'b00, cutoff}) ? {2'b00, cutoff} - root
                                             : root - {2'b00, cutoff};
            divn <= '0;
          end
        end
        ST_DIV_W: begin
          if (dv_done) begin
            qv   <= quo;
            divn <= divn + 1'b1;
            mop  <= MOP_TERM;
            axis <= 1'b0;
          end
        end
        ST_ACC: begin
          if (axis) begin
            accy <= sat_add(accy, term);
          end else begin
            accx <= sat_add(accx, term);
          end
          axis <= 1'b1;
        end
        ST_CHK: begin
          axis <= 1'b0;
          mop  <= MOP_VEL;
        end
        ST_VADD: begin
          vtmp <= clamp_v(sat_add(vel_sel, tmp));
          mop  <= MOP_POS;
        end
        ST_POS: pw <= pos_sel + dp;
        ST_BNC: begin
          // single wall reflection, clamp follows
          if (pw < 0) begin
            pw   <= -pw;
            vtmp <= clamp_v(-vtmp);
          end else if (pw > s64) begin
            pw   <= (s64 <<< 1) - pw;
            vtmp <= clamp_v(-vtmp);
          end
        end
        ST_CLP: begin
          if (axis) begin
            ry  <= pf[POS_W-1:0];
            rvy <= vtmp[POS_W-1:0];
          end else begin
            rx  <= pf[POS_W-1:0];
            rvx <= vtmp[POS_W-1:0];
          end
          axis <= 1'b1;
          mop  <= MOP_VEL;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid        <= 1'b1;
            out_data.new_x   <= rx;
            out_data.new_y   <= ry;
            out_data.new_vx  <= rvx;
            out_data.new_vy  <= rvy;
            out_data.accel_x <= accx;
            out_data.accel_y <= accy;
            accx             <= '0;
            accy             <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL_W)
    else $error("multiplier result outside its wait state");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_avail)
    else $error("queue popped while empty");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> accx == '0 && accy == '0 && out_valid)
    else $error("accumulators not cleared after result");

  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> wk.last_neighbor)
    else $error("result for an item that does not close a run");

endmodule

### rtl/pfv_front.sv
module pfv_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfv_pkg::in_item_t in_data,
  input  logic             pop,
  output logic             avail,
  output pfv_pkg::work_t   head
);
  import pfv_pkg::*;

  work_t              q [QDEPTH];
  logic [Q_PTR_W-1:0] wr;
  logic [Q_PTR_W-1:0] rd;
  logic [Q_CNT_W-1:0] cnt;
  logic [POS_W:0]     dx;
  logic [POS_W:0]     dy;
  logic [POS_W:0]     dx_n;
  logic [POS_W:0]     dy_n;
  work_t              cls;
  logic               push;

  // signed differences split into magnitude and sign
  always_comb begin
    dx   = {1'b0, in_data.nbr_x} - {1'b0, in_data.own_x};
    dy   = {1'b0, in_data.nbr_y} - {1'b0, in_data.own_y};
    dx_n = '0 - dx;
    dy_n = '0 - dy;
    cls.own_x         = in_data.own_x;
    cls.own_y         = in_data.own_y;
    cls.own_vx        = in_data.own_vx;
    cls.own_vy        = in_data.own_vy;
    cls.dx_neg        = dx[POS_W];
    cls.dy_neg        = dy[POS_W];
    cls.dx_mag        = dx[POS_W] ? dx_n[POS_W-1:0] : dx[POS_W-1:0];
    cls.dy_mag        = dy[POS_W] ? dy_n[POS_W-1:0] : dy[POS_W-1:0];
    cls.last_neighbor = in_data.last_neighbor;
  end

  assign in_stall = (cnt == Q_CNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign avail    = (cnt != '0);
  assign head     = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr <= (wr == Q_PTR_W'(QDEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == Q_PTR_W'(QDEPTH - 1)) ? '0 : rd + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr] <= cls;
    end
  end

endmodule

### rtl/pfv_mul.sv
module pfv_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  import pfv_pkg::*;

  logic [63:0]         a_r;
  logic [63:0]         b_r;
  logic [63:0]         pp;
  logic [1:0]          pp_sh;
  logic [MUL_PH_W-1:0] phase;
  logic                run;
  logic [127:0]        acc;
  logic [31:0]         ah;
  logic [31:0]         bh;
  logic [127:0]        ppx;

  // one 32x32 partial product per cycle, summed in the following cycle
  always_comb begin
    ah = phase[1] ? a_r[63:32] : a_r[31:0];
    bh = phase[0] ? b_r[63:32] : b_r[31:0];
    case (pp_sh)
      2'd0:    ppx = {64'd0, pp};
      2'd3:    ppx = {pp, 64'd0};
      default: ppx = {32'd0, pp, 32'd0};
    endcase
  end

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        phase <= '0;
      end else if (run) begin
        phase <= phase + 1'b1;
        if (phase == MUL_PH_W'(4)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (run) begin
      pp    <= 64'(ah) * 64'(bh);
      pp_sh <= phase[1:0];
      if (phase != '0) begin
        acc <= acc + ppx;
      end
    end
  end

endmodule

### rtl/pfv_div.sv
module pfv_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  quo
);
  import pfv_pkg::*;

  logic [63:0]          rem;
  logic [63:0]          lo;
  logic [63:0]          den_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic [63:0]          r2;
  logic                 take;

  always_comb begin
    r2   = {rem[62:0], lo[63]};
    take = rem[63] || (r2 >= den_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // quotient would not fit: saturate at once
        if (num[127:64] >= den) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[127:64];
      lo    <= num[63:0];
      den_r <= den;
      cnt   <= '0;
      quo   <= (num[127:64] >= den) ? '1 : '0;
    end else if (run) begin
      lo  <= {lo[62:0], 1'b0};
      cnt <= cnt + 1'b1;
      rem <= take ? r2 - den_r : r2;
      quo <= {quo[62:0], take};
    end
  end

endmodule

### rtl/pfv_sqrt.sv
module pfv_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [pfv_pkg::RAD_W-1:0]  rad,
  output logic              done,
  output logic [pfv_pkg::ROOT_W-1:0] root
);
  import pfv_pkg::*;

  logic [RAD_W-1:0]    rad_r;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_REM_W-1:0] rem2;
  logic [SQ_REM_W-1:0] trial;
  logic [SQ_CNT_W-1:0] cnt;
  logic                run;
  logic                take;

  // restoring square root, one result bit per cycle
  always_comb begin
    rem2  = {rem[SQ_REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    take  = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == SQ_CNT_W'(SQ_STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      rem   <= '0;
      root  <= '0;
      cnt   <= '0;
    end else if (run) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      rem   <= take ? rem2 - trial : rem2;
      root  <= {root[ROOT_W-2:0], take};
      cnt   <= cnt + 1'b1;
    end
  end

endmodule

### verif/particle_force_and_verlet_step_tb.sv
`timescale 1ns / 100ps

module particle_force_and_verlet_step_tb;
  import pfv_pkg::*;

  typedef struct {
    logic [47:0] x;
    logic [47:0] y;
    logic [47:0] vx;
    logic [47:0] vy;
    logic [63:0] ax;
    logic [63:0] ay;
  } state_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CUTOFF;
  logic [POS_W-1:0] cfg_data = '0;

  particle_force_and_verlet_step i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and accumulators
  logic [63:0] cut_r, minr_r, mass_r, step_r, arena_r;
  logic signed [63:0] sum_ax, sum_ay;
  state_rec_t expected_q[$];
  int n_errors = 0;
  int n_results = 0;
  int n_items = 0;
  int hold_cycles = 0;
  bit stall_random = 1'b1;

  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [63:0] sat_shr(logic [127:0] p, int sh);
    logic [127:0] q;
    q = p >> sh;
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic logic [63:0] sat_div(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / {64'd0, d};
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic logic signed [63:0] apply_sign(bit neg, logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000_0000_0000) ? I64_MIN : -$signed(mag);
    return (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? I64_MAX : $signed(mag);
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, I64_MAX})) return I64_MAX;
    if (s < $signed({1'b1, I64_MIN})) return I64_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_vel(logic signed [63:0] v);
    if (v > V_MAX) return V_MAX;
    if (v < V_MIN) return V_MIN;
    return v;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] d);
    logic [63:0] res, cand;
    res = 0;
    for (int b = 49; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= d) res = cand;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] repulsion(logic signed [63:0] d, logic [63:0] r);
    logic [63:0] a, k, w1, w, c, m;
    bit neg;
    neg = r < cut_r;
    a = neg ? cut_r - r : r - cut_r;
    m = (mass_r == 0) ? 64'd1 : mass_r;
    k = sat_div({32'd0, a, 32'd0}, r);
    w1 = sat_div({32'd0, k, 32'd0}, r);
    w = sat_div({32'd0, w1, 32'd0}, r);
    c = sat_div({32'd0, w, 32'd0}, m);
    return apply_sign(neg != (d < 0), sat_shr({64'd0, c} * {64'd0, abs64(d)}, 40));
  endfunction

  task automatic verlet_axis(inout logic signed [63:0] p, inout logic signed [63:0] v,
                             input logic signed [63:0] acc);
    logic signed [63:0] dv, dp, s;
    s = arena_r;
    dv = apply_sign(acc < 0, sat_shr({64'd0, abs64(acc)} * {64'd0, step_r}, 24));
    v = clamp_vel(add_sat(v, dv));
    dp = apply_sign(v < 0, sat_shr({64'd0, abs64(v)} * {64'd0, step_r}, 32));
    if (dp > STEP_LIMIT) dp = STEP_LIMIT;
    if (dp < -STEP_LIMIT) dp = -STEP_LIMIT;
    p = p + dp;
    if (p < 0) begin
      p = -p;
      v = clamp_vel(-v);
    end else if (p > s) begin
      p = 2 * s - p;
      v = clamp_vel(-v);
    end
    if (p < 0) p = 0;
    if (p > s) p = s;
  endtask

  task automatic predict_pair(in_item_t it);
    logic signed [63:0] px, py, vx, vy, dx, dy, r;
    logic [127:0] d2, m2;
    state_rec_t e;
    px = {16'd0, it.own_x};
    py = {16'd0, it.own_y};
    vx = {{16{it.own_vx[47]}}, it.own_vx};
    vy = {{16{it.own_vy[47]}}, it.own_vy};
    dx = $signed({16'd0, it.nbr_x}) - px;
    dy = $signed({16'd0, it.nbr_y}) - py;
    d2 = {64'd0, abs64(dx)} * {64'd0, abs64(dx)} + {64'd0, abs64(dy)} * {64'd0, abs64(dy)};
    m2 = {64'd0, minr_r} * {64'd0, minr_r};
    if (d2 <= {64'd0, cut_r} * {64'd0, cut_r}) begin
      if (m2 > d2) d2 = m2;
      r = floor_root(d2);
      // coincident points with zero min radius add nothing
      if (r != 0) begin
        sum_ax = add_sat(sum_ax, repulsion(dx, r));
        sum_ay = add_sat(sum_ay, repulsion(dy, r));
      end
    end
    if (!it.last_neighbor) return;
    e.ax = sum_ax;
    e.ay = sum_ay;
    verlet_axis(px, vx, sum_ax);
    verlet_axis(py, vy, sum_ay);
    e.x = px[47:0];
    e.y = py[47:0];
    e.vx = vx[47:0];
    e.vy = vy[47:0];
    expected_q.insert(expected_q.size(), e);
    sum_ax = 0;
    sum_ay = 0;
  endtask

  task automatic send_item(in_item_t it, int gap_max = 10);
    repeat ($urandom_range(0, gap_max)) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    predict_pair(it);
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    n_items++;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
    // an item outside the cutoff may still be in flight with no result
    repeat (450) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CUTOFF: cut_r = val;
      REG_MINR: minr_r = val;
      REG_MASS: mass_r = val;
      REG_STEP: step_r = val;
      REG_ARENA: arena_r = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [47:0] c, logic [47:0] m, logic [47:0] ms,
                          logic [47:0] dt, logic [47:0] s);
    write_reg(REG_CUTOFF, c);
    write_reg(REG_MINR, m);
    write_reg(REG_MASS, ms);
    write_reg(REG_STEP, dt);
    write_reg(REG_ARENA, s);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 5))
      0: return 48'd0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return 48'h8000_0000_0000;
      3: return 48'h7FFF_FFFF_FFFF;
      default: return rand48();
    endcase
  endfunction

  // neighbor near the particle so the pair mostly lands inside the cutoff
  function automatic in_item_t near_pair(logic [47:0] ox, logic [47:0] oy,
                                         logic [47:0] vx, logic [47:0] vy,
                                         logic [47:0] spread, bit last);
    in_item_t it;
    logic [48:0] span;
    span = {1'b0, spread} + 49'd1;
    it.own_x = ox;
    it.own_y = oy;
    it.own_vx = vx;
    it.own_vy = vy;
    it.nbr_x = 48'(ox + ($urandom_range(0, 1) ? rand48() % span : -(rand48() % span)));
    it.nbr_y = 48'(oy + ($urandom_range(0, 1) ? rand48() % span : -(rand48() % span)));
    it.last_neighbor = last;
    return it;
  endfunction

  task automatic random_runs(int n_pairs, logic [47:0] spread, int gap_max = 10);
    int left, len;
    logic [47:0] ox, oy, vx, vy;
    left = n_pairs;
    while (left > 0) begin
      len = $urandom_range(1, 6);
      ox = ($urandom_range(0, 7) == 0) ? pick48() : rand48() % (arena_r + 1);
      oy = ($urandom_range(0, 7) == 0) ? pick48() : rand48() % (arena_r + 1);
      vx = ($urandom_range(0, 3) == 0) ? pick48()
                                       : {{16{1'($urandom_range(0, 1))}}, 32'(rand48())};
      vy = ($urandom_range(0, 3) == 0) ? pick48()
                                       : {{16{1'($urandom_range(0, 1))}}, 32'(rand48())};
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(near_pair(pick48(), pick48(), pick48(), pick48(), rand48(), i == len - 1),
                    gap_max);
        else
          send_item(near_pair(ox, oy, vx, vy, spread, i == len - 1), gap_max);
      end
      left -= len;
    end
  endtask

  task automatic test_directed();
    logic [47:0] c;
    c = cut_r[47:0];
    // lone neighbor within range, closing the run
    send_item(near_pair(48'h8000_0000, 48'h8000_0000, 0, 0, c / 2, 1'b1));
    // coincident points clamp to min radius
    send_item(near_pair(48'h4000_0000, 48'h4000_0000, 48'h10_0000, 0, 0, 1'b0));
    send_item(near_pair(48'h4000_0000, 48'h4000_0000, 48'h10_0000, 0, 0, 1'b1));
    // neighbor well outside the cutoff
    send_item('{48'd100, 48'd100, 48'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1});
    // field extremes and velocity extremes
    send_item('{48'hFFFF_FFFF_FFFF, 48'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                48'hFFFF_FFFF_FFFF, 48'd0, 1'b1});
    send_item('{48'd0, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                48'd0, 48'hFFFF_FFFF_FFFF, 1'b1});
    // wall bounce on both sides
    send_item('{48'd10, 48'hFFFF_0000, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                48'd10, 48'hFFFF_0000, 1'b1});
    // crowding on random sides, accumulators summed over a long run
    for (int i = 0; i < 8; i++)
      send_item(near_pair(48'h8000_0000, 48'h8000_0000, 48'hFFFF_FFF0_0000, 0, c / 4, i == 7));
    drain_results();
    // coincident points with zero min radius
    write_reg(REG_MINR, 0);
    send_item('{48'h1234_5678, 48'h1234_5678, 0, 0, 48'h1234_5678, 48'h1234_5678, 1'b1});
    drain_results();
  endtask

  task automatic test_register_settings();
    // default, then extremes (zero mass, full cutoff, huge step, tiny arena), then mid values
    set_regs(42949673, 429497, 42949673, 2147484, 48'd4294967296);
    random_runs(200, 48'd42949673);
    drain_results();
    set_regs(48'hFFFF_FFFF_FFFF, 0, 0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    random_runs(150, 48'hFFFF_FFFF_FFFF);
    drain_results();
    set_regs(0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 1);
    random_runs(100, 48'd1000);
    drain_results();
    set_regs(48'h1_0000_0000, 48'h10_0000, 1, 48'h100_0000, 48'h10_0000_0000);
    random_runs(150, 48'h1_0000_0000);
    drain_results();
  endtask

  task automatic test_random_configs();
    for (int k = 0; k < 6; k++) begin
      set_regs(rand48() >> $urandom_range(0, 24), rand48() >> $urandom_range(8, 40),
               rand48() >> $urandom_range(0, 40), rand48() >> $urandom_range(0, 30),
               rand48() >> $urandom_range(0, 16));
      random_runs(120, cut_r[47:0]);
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    set_regs(42949673, 429497, 42949673, 2147484, 48'd4294967296);
    stall_random = 1'b0;
    hold_cycles = 10000;
    random_runs(40, 48'd42949673, 0);
    stall_random = 1'b1;
    drain_results();
    // sender waits for all results of a batch, then continues
    random_runs(100, 48'd42949673);
    while (expected_q.size() != 0) @(posedge clk);
    random_runs(100, 48'd42949673);
    drain_results();
  endtask

  // receiver stall: long hold when asked, none when random stalls are off, else random per result
  initial begin
    out_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (!stall_random) begin
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
        else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(0, 9)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    state_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data.new_x !== e.x || out_data.new_y !== e.y || out_data.new_vx !== e.vx ||
            out_data.new_vy !== e.vy || out_data.accel_x !== e.ax ||
            out_data.accel_y !== e.ay) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp x=%h y=%h vx=%h vy=%h ax=%h ay=%h got %p",
                     e.x, e.y, e.vx, e.vy, e.ax, e.ay, out_data);
        end
      end
    end
  end

  initial begin
    #300ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cut_r = CUTOFF_RST;
    minr_r = MINR_RST;
    mass_r = MASS_RST;
    step_r = STEP_RST;
    arena_r = ARENA_RST;
    sum_ax = 0;
    sum_ay = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_settings();
    test_random_configs();
    test_backpressure();
    if (expected_q.size() != 0) n_errors += expected_q.size();
    $display("covered %0d neighbor items and %0d particle updates over varied register",
             n_items, n_results);
    $display("settings, wall bounces, saturation and long output back-pressure");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
